/* src/frequent_item_candidate_tracker_unit_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the frequent item candidate tracker
// Both macros expect clk_i, and FICT_ASSERT also rst_ni, to be visible where they are used.
// ---------------------------------------------------------------------------
`ifndef FREQUENT_ITEM_CANDIDATE_TRACKER_UNIT_MACROS_SVH
`define FREQUENT_ITEM_CANDIDATE_TRACKER_UNIT_MACROS_SVH

// Checked only while the block is out of reset.
`define FICT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define FICT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/fict_pkg.sv */
// ---------------------------------------------------------------------------
// fict_pkg
// Shared types, constants and helpers of the frequent item candidate tracker.
// ---------------------------------------------------------------------------
package fict_pkg;

  localparam int DEF_NUM_SLOTS   = 3;
  localparam int DEF_ID_WIDTH    = 32;
  localparam int DEF_COUNT_WIDTH = 32;

  // Width of the reported slot index field.
  localparam int SLOT_W = 2;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_PUSH   = 1'b0,
    OP_REPORT = 1'b1
  } op_e;

  typedef enum logic {
    ST_RUN,
    ST_REPORT
  } back_state_e;

  // Command handshake from the queue to the back end.
  typedef struct packed {
    logic valid;
    op_e  op;
  } cmd_ctrl_t;

  // Rounds a bit count up to whole bytes.
  function automatic int byte_pad(input int w);
    return ((w + 7) / 8) * 8;
  endfunction

endpackage

/* src/fict_front.sv */
// ---------------------------------------------------------------------------
// fict_front
// Accepts requests, decodes the function bit and queues the commands.
// ---------------------------------------------------------------------------
module fict_front
  import fict_pkg::*;
#(
  parameter int ID_WIDTH = DEF_ID_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_func_i,
  input  logic [ID_WIDTH-1:0] in_id_i,
  output cmd_ctrl_t           cmd_o,
  output logic [ID_WIDTH-1:0] cmd_id_o,
  input  logic                cmd_ready_i
);

  op_e                 op_mem [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] id_mem [QUEUE_DEPTH];

  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              push, pop;
  op_e               in_op;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_op      = in_func_i ? OP_REPORT : OP_PUSH;
  assign in_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign pop        = cmd_o.valid && cmd_ready_i;

  assign cmd_o.valid = (count_q != '0);
  assign cmd_o.op    = op_mem[rd_ptr_q];
  assign cmd_id_o    = id_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      op_mem[wr_ptr_q] <= in_op;
      id_mem[wr_ptr_q] <= in_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* src/fict_back.sv */
// ---------------------------------------------------------------------------
// fict_back
// Holds the candidate slots, applies pushes and walks the slots on a report.
// ---------------------------------------------------------------------------
module fict_back
  import fict_pkg::*;
#(
  parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
  parameter int ID_WIDTH    = DEF_ID_WIDTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_ctrl_t              cmd_i,
  input  logic [ID_WIDTH-1:0]    cmd_id_i,
  output logic                   cmd_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [SLOT_W-1:0]      out_slot_o,
  output logic [ID_WIDTH-1:0]    out_id_o,
  output logic [COUNT_WIDTH-1:0] out_count_o,
  output logic                   out_last_o
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  logic [ID_WIDTH-1:0]    ids_q [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] cnt_q [NUM_SLOTS];

  back_state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  logic                   out_valid_q, out_valid_d;
  logic [SLOT_W-1:0]      out_slot_q;
  logic [ID_WIDTH-1:0]    out_id_q;
  logic [COUNT_WIDTH-1:0] out_count_q;
  logic                   out_last_q;

  logic                 out_free;
  logic                 do_push;
  logic                 load;
  logic [IDX_W-1:0]     load_idx;
  logic [NUM_SLOTS-1:0] hit, first_hit, first_free;
  logic                 any_hit, any_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Slot match and first-empty search, all slots in parallel.
  always_comb begin
    logic seen_hit, seen_free;
    seen_hit   = 1'b0;
    seen_free  = 1'b0;
    hit        = '0;
    first_hit  = '0;
    first_free = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      hit[k]        = (cnt_q[k] != '0) && (ids_q[k] == cmd_id_i);
      first_hit[k]  = hit[k] && !seen_hit;
      first_free[k] = (cnt_q[k] == '0) && !seen_free;
      seen_hit      = seen_hit || hit[k];
      seen_free     = seen_free || (cnt_q[k] == '0);
    end
    any_hit  = seen_hit;
    any_free = seen_free;
  end

  // Next state of the report sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (cmd_i.valid && cmd_i.op == OP_REPORT && out_free && LAST_IDX != '0) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free && idx_q == LAST_IDX) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  // Sequencer outputs: command pop, result load and slot index.
  always_comb begin
    cmd_ready_o = 1'b0;
    do_push     = 1'b0;
    load        = 1'b0;
    load_idx    = '0;
    idx_d       = idx_q;
    case (state_q)
      ST_RUN: begin
        if (cmd_i.valid && cmd_i.op == OP_PUSH) begin
          cmd_ready_o = 1'b1;
          do_push     = 1'b1;
        end else if (cmd_i.valid && out_free) begin
          cmd_ready_o = 1'b1;
          load        = 1'b1;
          idx_d       = (LAST_IDX == '0) ? '0 : IDX_W'(1);
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          load     = 1'b1;
          load_idx = idx_q;
          idx_d    = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_slot_q  <= SLOT_W'(load_idx);
      out_id_q    <= ids_q[load_idx];
      out_count_q <= cnt_q[load_idx];
      out_last_q  <= (load_idx == LAST_IDX);
    end
  end

  // Slot update: increment on a match, claim the first empty slot, or age all.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        ids_q[k] <= '0;
        cnt_q[k] <= '0;
      end
    end else if (do_push) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (any_hit) begin
          if (first_hit[k] && cnt_q[k] != '1) begin
            cnt_q[k] <= cnt_q[k] + 1'b1;
          end
        end else if (any_free) begin
          if (first_free[k]) begin
            ids_q[k] <= cmd_id_i;
            cnt_q[k] <= COUNT_WIDTH'(1);
          end
        end else begin
          cnt_q[k] <= cnt_q[k] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_slot_o  = out_slot_q;
  assign out_id_o    = out_id_q;
  assign out_count_o = out_count_q;
  assign out_last_o  = out_last_q;

endmodule

/* src/frequent_item_candidate_tracker_unit.sv */
// ---------------------------------------------------------------------------
// frequent_item_candidate_tracker_unit
// Streaming heavy-hitter finder with a small set of counted candidate slots.
// ---------------------------------------------------------------------------
//  Channel   Direction  Carries
//  s_axis    in         tuser: func; tdata: item_id
//  m_axis    out        tdata: slot, candidate_id, hit_count; tlast: last
//
//  Pushes stream at one per cycle while no report is being sent.
//  A report sends NUM_SLOTS results, one per cycle unless the output stalls, through the output register.
//  The two-entry command queue lets requests keep arriving while results stall.
//  Reset empties every slot and the queue; no clearing pass is needed.
// ---------------------------------------------------------------------------
module frequent_item_candidate_tracker_unit
  import fict_pkg::*;
#(
  parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
  parameter int ID_WIDTH    = DEF_ID_WIDTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int IN_DATA_W   = byte_pad(ID_WIDTH),
  parameter int OUT_DATA_W  = byte_pad(SLOT_W + ID_WIDTH + COUNT_WIDTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // item_id
  input  logic                  s_axis_tuser_i,  // func
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // slot, candidate_id, hit_count
  output logic                  m_axis_tlast_o
);

  cmd_ctrl_t              cmd;
  logic [ID_WIDTH-1:0]    cmd_id;
  logic                   cmd_ready;
  logic [SLOT_W-1:0]      out_slot;
  logic [ID_WIDTH-1:0]    out_id;
  logic [COUNT_WIDTH-1:0] out_count;

  fict_front #(
    .ID_WIDTH (ID_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_func_i   (s_axis_tuser_i),
    .in_id_i     (s_axis_tdata_i[ID_WIDTH-1:0]),
    .cmd_o       (cmd),
    .cmd_id_o    (cmd_id),
    .cmd_ready_i (cmd_ready)
  );

  fict_back #(
    .NUM_SLOTS   (NUM_SLOTS),
    .ID_WIDTH    (ID_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_id_i    (cmd_id),
    .cmd_ready_o (cmd_ready),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_slot_o  (out_slot),
    .out_id_o    (out_id),
    .out_count_o (out_count),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = OUT_DATA_W'({out_count, out_id, out_slot});

endmodule

/* src/fict_checker.sv */
// ---------------------------------------------------------------------------
// fict_checker
// Port-level checks of the frequent item candidate tracker, bound to the top.
// ---------------------------------------------------------------------------
`include "frequent_item_candidate_tracker_unit_macros.svh"

module fict_checker
  import fict_pkg::*;
#(
  parameter int NUM_SLOTS   = DEF_NUM_SLOTS,
  parameter int ID_WIDTH    = DEF_ID_WIDTH,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  parameter int IN_DATA_W   = byte_pad(ID_WIDTH),
  parameter int OUT_DATA_W  = byte_pad(SLOT_W + ID_WIDTH + COUNT_WIDTH)
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                  s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  m_axis_tlast_o
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  // A waiting request is held by the sender until it is taken.
  `FICT_ASSERT(a_in_hold, s_axis_tvalid_i && !s_axis_tready_o |=> s_axis_tvalid_i && $stable(s_axis_tdata_i) && $stable(s_axis_tuser_i), "waiting request changed")

  // A stalled result keeps its contents.
  `FICT_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "stalled result changed")

  // The final result of a report names the highest slot.
  `FICT_ASSERT(a_last_slot, m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[SLOT_W-1:0] == LAST_SLOT, "last flag on wrong slot")

  // A report run has no gaps once it has started draining.
  `FICT_ASSERT(a_run_dense, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o, "gap inside a report run")

  // No result is offered while reset is held.
  `FICT_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !m_axis_tvalid_o, "result valid during reset")

endmodule

bind frequent_item_candidate_tracker_unit fict_checker #(
  .NUM_SLOTS   (NUM_SLOTS),
  .ID_WIDTH    (ID_WIDTH),
  .COUNT_WIDTH (COUNT_WIDTH),
  .IN_DATA_W   (IN_DATA_W),
  .OUT_DATA_W  (OUT_DATA_W)
) u_fict_checker (.*);

/* verif/frequent_item_candidate_tracker_unit_tb.sv */
// ---------------------------------------------------------------------------
// frequent_item_candidate_tracker_unit_tb
// Streams push and report requests into the tracker and checks every slot
// result against a cycle-free predictor of the three candidate slots.
// ---------------------------------------------------------------------------
module frequent_item_candidate_tracker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fict_pkg::*;

  localparam int NUM_SLOTS   = DEF_NUM_SLOTS;
  localparam int ID_W        = DEF_ID_WIDTH;
  localparam int CNT_W       = DEF_COUNT_WIDTH;
  localparam int IN_W        = ((ID_W + 7) / 8) * 8;
  localparam int PAD_LSB     = SLOT_W + ID_W + CNT_W;
  localparam int OUT_W       = ((PAD_LSB + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int BURST_LEN   = 8;
  localparam int PHASE_ITEMS = 48;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   cand_id;
    logic [CNT_W-1:0]  count;
    logic              last;
  } slot_report_t;

  class tracker_scoreboard;
    logic [ID_W-1:0]  cand_ids[NUM_SLOTS];
    logic [CNT_W-1:0] hit_counts[NUM_SLOTS];
    slot_report_t     pending_reports[$];
    int mismatches;
    int requests;
    int reports;
    int results_checked;
    int saturated_pushes;

    function new();
      for (int k = 0; k < NUM_SLOTS; k++) begin
        cand_ids[k]   = '0;
        hit_counts[k] = '0;
      end
      mismatches       = 0;
      requests         = 0;
      reports          = 0;
      results_checked  = 0;
      saturated_pushes = 0;
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 30) $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Updates the predicted slots for one accepted request.
    function void note_request(op_e op, logic [ID_W-1:0] id);
      bit done;
      slot_report_t rep;
      done = 0;
      requests++;
      if (op == OP_PUSH) begin
        // Only a nonempty slot can match; a stale ID in an empty slot is ignored.
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (!done && hit_counts[k] != '0 && cand_ids[k] == id) begin
            if (hit_counts[k] != {CNT_W{1'b1}}) hit_counts[k] = hit_counts[k] + 1'b1;
            else saturated_pushes++;
            done = 1;
          end
        end
        for (int k = 0; k < NUM_SLOTS; k++) begin
          if (!done && hit_counts[k] == '0) begin
            cand_ids[k]   = id;
            hit_counts[k] = CNT_W'(1);
            done = 1;
          end
        end
        if (!done) begin
          for (int k = 0; k < NUM_SLOTS; k++) hit_counts[k] = hit_counts[k] - 1'b1;
        end
      end else begin
        reports++;
        for (int k = 0; k < NUM_SLOTS; k++) begin
          rep.slot    = k[SLOT_W-1:0];
          rep.cand_id = cand_ids[k];
          rep.count   = hit_counts[k];
          rep.last    = (k == NUM_SLOTS - 1);
          pending_reports.push_back(rep);
        end
      end
    endfunction

    task check_result(logic [OUT_W-1:0] data, logic last);
      slot_report_t want;
      if (pending_reports.size() == 0) begin
        flag_mismatch($sformatf("unexpected result, tdata %h", data));
        return;
      end
      want = pending_reports.pop_front();
      results_checked++;
      if (data[SLOT_W-1:0] !== want.slot)
        flag_mismatch($sformatf("slot %0d, expected %0d", data[SLOT_W-1:0], want.slot));
      if (data[SLOT_W +: ID_W] !== want.cand_id)
        flag_mismatch($sformatf("slot %0d candidate_id %h, expected %h",
                                want.slot, data[SLOT_W +: ID_W], want.cand_id));
      if (data[SLOT_W+ID_W +: CNT_W] !== want.count)
        flag_mismatch($sformatf("slot %0d hit_count %0d, expected %0d",
                                want.slot, data[SLOT_W+ID_W +: CNT_W], want.count));
      if (last !== want.last)
        flag_mismatch($sformatf("slot %0d tlast %b, expected %b", want.slot, last, want.last));
      if (data[OUT_W-1:PAD_LSB] !== '0)
        flag_mismatch($sformatf("slot %0d padding bits %h not zero",
                                want.slot, data[OUT_W-1:PAD_LSB]));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [IN_W-1:0]  s_axis_tdata_i;   // item_id
  logic             s_axis_tuser_i;   // func
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [OUT_W-1:0] m_axis_tdata_o;   // slot, candidate_id, hit_count
  logic             m_axis_tlast_o;

  tracker_scoreboard sb;
  int src_idle_pct;
  int sink_idle_pct;
  int cycle_count;

  frequent_item_candidate_tracker_unit #(
    .NUM_SLOTS  (NUM_SLOTS),
    .ID_WIDTH   (ID_W),
    .COUNT_WIDTH(CNT_W)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Result side: sample at the rising edge, change tready at the falling edge.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
        sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
      @(negedge clk_i);
      m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so back-to-back requests need no extra step.
  task automatic send_request(op_e op, logic [ID_W-1:0] id);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= $urandom;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= id;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request(op, id);
    @(negedge clk_i);
  endtask

  task automatic drain_reports();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_reports.size() != 0) @(negedge clk_i);
  endtask

  // Mostly a skewed stream around two hot IDs, so slots fill, match and
  // get decremented, with reports sprinkled in and some fully random IDs.
  task automatic run_random_phase(int src_pct, int sink_pct);
    logic [ID_W-1:0] pool[6];
    int r;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    foreach (pool[i]) pool[i] = $urandom;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      r = $urandom_range(99);
      if (r < 12) send_request(OP_REPORT, $urandom);
      else if (r < 55) send_request(OP_PUSH, pool[$urandom_range(1)]);
      else if (r < 85) send_request(OP_PUSH, pool[$urandom_range(5)]);
      else send_request(OP_PUSH, $urandom);
    end
    drain_reports();
  endtask

  initial begin
    sb              = new();
    cycle_count     = 0;
    rst_ni          = 1'b1;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_PUSH;
    m_axis_tready_i = 1'b0;
    src_idle_pct    = 26;
    sink_idle_pct   = 84;
    // A real falling edge on the reset, seen by every asynchronously reset register.
    #1;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty report, fill all slots, match, decrement on a full
    // table, stale IDs in empty slots, and a report with a nonzero item_id.
    send_request(OP_REPORT, '0);
    send_request(OP_PUSH, '0);
    send_request(OP_PUSH, '1);
    send_request(OP_PUSH, '0);
    send_request(OP_PUSH, 32'h5A5A_A5A5);
    send_request(OP_REPORT, 32'hFFFF_FFFF);
    send_request(OP_PUSH, 32'hAAAA_AAAA);
    send_request(OP_REPORT, 32'h5555_5555);
    send_request(OP_PUSH, 32'h5A5A_A5A5);
    send_request(OP_PUSH, 32'h5A5A_A5A5);
    send_request(OP_PUSH, 32'h5555_5555);
    send_request(OP_PUSH, 32'hAAAA_AAAA);
    send_request(OP_REPORT, '0);
    send_request(OP_PUSH, 32'h0000_0001);
    send_request(OP_PUSH, 32'h8000_0000);
    send_request(OP_PUSH, 32'h8000_0000);
    send_request(OP_REPORT, 32'h1234_5678);

    // A short run of one ID builds up its count.
    for (int i = 0; i < BURST_LEN; i++) send_request(OP_PUSH, 32'h0F0F_F0F0);
    send_request(OP_REPORT, '0);
    drain_reports();

    run_random_phase(26, 84);
    run_random_phase(84, 26);
    run_random_phase(0, 0);

    repeat (8) @(posedge clk_i);
    $display("Sent %0d requests (%0d reports) and compared %0d slot results.",
             sb.requests, sb.reports, sb.results_checked);
    $display("Saturated-count pushes: %0d; mismatches: %0d.",
             sb.saturated_pushes, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d results still outstanding.",
             cycle_count, sb.pending_reports.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
